/* design/ace_pkg.sv */
// ----------------------------------------------------------------------------
// ace_pkg
// Shared types and byte constants for the SGR color escape encoder.
// ----------------------------------------------------------------------------
package ace_pkg;

  // One screen cell as it enters the block
  typedef struct packed {
    logic [7:0] char_code;
    logic [3:0] fg_color;
    logic [2:0] bg_color;
    logic       row_end;
    logic       screen_start;
  } ace_in_t;

  // One byte of the terminal text stream
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } ace_out_t;

  // Byte slots of one cell, in stream order
  localparam int SLOT_ESC     = 0;
  localparam int SLOT_LBR     = 1;
  localparam int SLOT_BOLD    = 2;
  localparam int SLOT_BOLDSEP = 3;
  localparam int SLOT_RSTSEP  = 4;
  localparam int SLOT_FG3     = 5;
  localparam int SLOT_FGDIG   = 6;
  localparam int SLOT_FGSEP   = 7;
  localparam int SLOT_BG4     = 8;
  localparam int SLOT_BGDIG   = 9;
  localparam int SLOT_M       = 10;
  localparam int SLOT_CHAR    = 11;
  localparam int SLOT_CR      = 12;
  localparam int SLOT_LF      = 13;
  localparam int NUM_SLOTS    = 14;

  typedef logic [NUM_SLOTS-1:0] ace_mask_t;

  // Classified cell: which slots to send plus the variable bytes
  typedef struct packed {
    ace_mask_t  mask;
    logic [2:0] fg_digit;
    logic [2:0] bg_digit;
    logic [7:0] char_code;
  } ace_cmd_t;

  localparam logic [7:0] BYTE_ESC  = 8'h1B;
  localparam logic [7:0] BYTE_LBR  = 8'h5B;
  localparam logic [7:0] BYTE_ONE  = 8'h31;
  localparam logic [7:0] BYTE_SEMI = 8'h3B;
  localparam logic [7:0] BYTE_3    = 8'h33;
  localparam logic [7:0] BYTE_4    = 8'h34;
  localparam logic [7:0] BYTE_ZERO = 8'h30;
  localparam logic [7:0] BYTE_M    = 8'h6D;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_LF   = 8'h0A;

  localparam logic [3:0] FG_RESET  = 4'd7;
  localparam logic [2:0] BG_RESET  = 3'd0;

endpackage

/* design/ace_front.sv */
// ----------------------------------------------------------------------------
// ace_front
// Accepts cells, tracks the current colors and builds the slot mask.
// ----------------------------------------------------------------------------
module ace_front import ace_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  ace_in_t  item,
  input  logic     q_full,
  output logic     q_push,
  output ace_cmd_t cmd
);

  logic [3:0] prev_fg;
  logic [2:0] prev_bg;
  logic [3:0] base_fg;
  logic [2:0] base_bg;
  logic [2:0] cmp_fg;
  logic [2:0] cmp_bg;
  logic       bold;
  logic       rst_sgr;
  logic       fg_chg;
  logic       bg_chg;
  logic       any_param;

  assign q_push = push && !q_full;

  always_comb begin
    base_fg = item.screen_start ? FG_RESET : prev_fg;
    base_bg = item.screen_start ? BG_RESET : prev_bg;
    bold    = !base_fg[3] && item.fg_color[3];
    rst_sgr = base_fg[3] && !item.fg_color[3];
    // a full reset puts the colors back to their defaults
    cmp_fg  = rst_sgr ? FG_RESET[2:0] : base_fg[2:0];
    cmp_bg  = rst_sgr ? BG_RESET : base_bg;
    fg_chg  = cmp_fg != item.fg_color[2:0];
    bg_chg  = cmp_bg != item.bg_color;
    any_param = fg_chg || bg_chg;

    cmd.mask               = '0;
    cmd.mask[SLOT_ESC]     = bold || rst_sgr || any_param;
    cmd.mask[SLOT_LBR]     = bold || rst_sgr || any_param;
    cmd.mask[SLOT_BOLD]    = bold;
    // drop the trailing separator: each one stands only if a color follows
    cmd.mask[SLOT_BOLDSEP] = bold && any_param;
    cmd.mask[SLOT_RSTSEP]  = rst_sgr && any_param;
    cmd.mask[SLOT_FG3]     = fg_chg;
    cmd.mask[SLOT_FGDIG]   = fg_chg;
    cmd.mask[SLOT_FGSEP]   = fg_chg && bg_chg;
    cmd.mask[SLOT_BG4]     = bg_chg;
    cmd.mask[SLOT_BGDIG]   = bg_chg;
    cmd.mask[SLOT_M]       = bold || rst_sgr || any_param;
    cmd.mask[SLOT_CHAR]    = 1'b1;
    cmd.mask[SLOT_CR]      = item.row_end;
    cmd.mask[SLOT_LF]      = item.row_end;
    cmd.fg_digit           = item.fg_color[2:0];
    cmd.bg_digit           = item.bg_color;
    cmd.char_code          = item.char_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_fg <= FG_RESET;
      prev_bg <= BG_RESET;
    end else if (q_push) begin
      prev_fg <= item.fg_color;
      prev_bg <= item.bg_color;
    end
  end

endmodule

/* design/ace_queue.sv */
// ----------------------------------------------------------------------------
// ace_queue
// Small register queue of classified cells between front and back.
// ----------------------------------------------------------------------------
module ace_queue import ace_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  ace_cmd_t wr_data,
  input  logic     rd_en,
  output ace_cmd_t rd_data,
  output logic     q_full,
  output logic     q_empty
);

  localparam int AW = $clog2(DEPTH);

  ace_cmd_t      mem [DEPTH];
  logic [AW:0]   wr_ptr;
  logic [AW:0]   rd_ptr;

  assign q_empty = wr_ptr == rd_ptr;
  assign q_full  = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign rd_data = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  a_no_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");

endmodule

/* design/ace_back.sv */
// ----------------------------------------------------------------------------
// ace_back
// Byte sequencer: walks a cell's slot mask, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module ace_back import ace_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ace_cmd_t q_head,
  input  logic     q_empty,
  output logic     q_pop,
  input  logic     pop,
  output logic     empty,
  output ace_out_t result
);

  logic      cur_valid;
  ace_cmd_t  cur;
  ace_mask_t first;
  ace_mask_t rest;
  logic      out_valid;
  ace_out_t  out_data;
  logic      out_ready;
  logic      emit;
  logic      done;
  logic [7:0] byte_sel;

  // lowest set slot goes first
  assign first     = cur.mask & (~cur.mask + 1'b1);
  assign rest      = cur.mask & ~first;
  assign out_ready = !out_valid || pop;
  assign emit      = cur_valid && out_ready;
  assign done      = emit && (rest == '0);
  assign q_pop     = (!cur_valid || done) && !q_empty;

  assign empty  = !out_valid;
  assign result = out_data;

  always_comb begin
    byte_sel = ({8{first[SLOT_ESC]}}     & BYTE_ESC)
             | ({8{first[SLOT_LBR]}}     & BYTE_LBR)
             | ({8{first[SLOT_BOLD]}}    & BYTE_ONE)
             | ({8{first[SLOT_BOLDSEP]}} & BYTE_SEMI)
             | ({8{first[SLOT_RSTSEP]}}  & BYTE_SEMI)
             | ({8{first[SLOT_FG3]}}     & BYTE_3)
             | ({8{first[SLOT_FGDIG]}}   & (BYTE_ZERO | {5'b0, cur.fg_digit}))
             | ({8{first[SLOT_FGSEP]}}   & BYTE_SEMI)
             | ({8{first[SLOT_BG4]}}     & BYTE_4)
             | ({8{first[SLOT_BGDIG]}}   & (BYTE_ZERO | {5'b0, cur.bg_digit}))
             | ({8{first[SLOT_M]}}       & BYTE_M)
             | ({8{first[SLOT_CHAR]}}    & cur.char_code)
             | ({8{first[SLOT_CR]}}      & BYTE_CR)
             | ({8{first[SLOT_LF]}}      & BYTE_LF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
      if (out_ready) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end else if (emit) begin
      cur.mask <= rest;
    end
    if (emit) begin
      out_data.out_byte  <= byte_sel;
      out_data.last_byte <= done;
    end
  end

  a_cur_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.mask != '0))
    else $error("active cell has no bytes left");

  a_esc_framed: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && cur.mask[SLOT_ESC]) |-> (cur.mask[SLOT_LBR] && cur.mask[SLOT_M]))
    else $error("escape without bracket or terminator");

  a_cr_lf: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && cur.mask[SLOT_CR]) |-> cur.mask[SLOT_LF])
    else $error("CR pending without LF");

endmodule

/* design/ansi_color_escape_encoder.sv */
// ----------------------------------------------------------------------------
// ansi_color_escape_encoder
// Turns screen cells into a terminal byte stream with SGR color escapes.
// ----------------------------------------------------------------------------
//  channel | handshake       | payload
//  --------+-----------------+-----------------------------------------------
//  cells   | push / full     | item   : char, fg 0-15, bg 0-7, row end, start
//  bytes   | pop / empty     | result : out_byte, last_byte
//
// A cell yields 1 to 13 output bytes; the back sequencer sends one byte per
// cycle while the output is not held. The front takes a new cell each cycle
// until the cell queue (QUEUE_DEPTH entries, a power of two, at least 2) fills.
// Reset sets the remembered colors to 7 and 0 and empties queue and output.
// With pop low the waiting byte holds and the queue keeps filling.
// ----------------------------------------------------------------------------
module ansi_color_escape_encoder import ace_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  ace_in_t  item,
  input  logic     pop,
  output logic     empty,
  output ace_out_t result
);

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  ace_cmd_t cmd;
  ace_cmd_t q_head;

  assign full = q_full;

  ace_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .cmd    (cmd)
  );

  ace_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (cmd),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  ace_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule
